FILE: design/dmmt_pkg.sv
package dmmt_pkg;

  // Field widths
  localparam int SAMPLE_W = 18;
  localparam int SLOT_W   = 4;
  localparam int MIN_W    = 21;
  localparam int MAX_W    = 18;
  localparam int MEAN_W   = 26;
  localparam int SUM_W    = 40;
  localparam int COUNT_W  = 16;
  localparam int FRAC_W   = 8;

  // Divider: dividend is sum << FRAC_W, one quotient bit per cycle
  localparam int DVD_W     = SUM_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int REM_W     = COUNT_W;

  // Stream payload widths (byte aligned)
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = SLOT_W + MIN_W + MAX_W + MEAN_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Day bookkeeping
  localparam int                   DAYS            = 7;
  localparam logic [COUNT_W-1:0]   SAMPLES_PER_DAY = COUNT_W'(1440);
  localparam logic [MIN_W-1:0]     MIN_EMPTY       = MIN_W'(21'h100000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: design/dmmt_div.sv
module dmmt_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [dmmt_pkg::DVD_W-1:0]         dividend,
  input  logic [dmmt_pkg::COUNT_W-1:0]       divisor,
  output logic [dmmt_pkg::MEAN_W-1:0]        quotient,
  output dmmt_pkg::div_sts_t                 sts
);

  // Restoring divider, one bit per cycle. Only the low MEAN_W quotient bits are kept.
  logic [dmmt_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [dmmt_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [dmmt_pkg::MEAN_W-1:0]    quo_r, quo_nxt;
  logic [dmmt_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  logic [dmmt_pkg::REM_W:0]       rem_sh;
  logic [dmmt_pkg::REM_W:0]       rem_sub;
  logic                           ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[dmmt_pkg::DVD_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = dmmt_pkg::DIV_CNT_W'(dmmt_pkg::DVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[dmmt_pkg::DVD_W-2:0], 1'b0};
      rem_nxt = ge ? rem_sub[dmmt_pkg::REM_W-1:0] : rem_sh[dmmt_pkg::REM_W-1:0];
      quo_nxt = {quo_r[dmmt_pkg::MEAN_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: design/daily_min_max_mean_tracker_unit.sv
// Flow: capture the beat, update the day stats, then the bit-serial divider
//   forms the mean, one quotient bit per cycle. in_tready is high only while
//   the sequencer is idle, so a new sample waits until the last result is
//   loaded. A waiting result does not block the next input beat.
// Reset (rst_n, synchronous, active low): sum and count cleared, min set to
//   0x100000, max and day slot cleared, no result pending.
module daily_min_max_mean_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dmmt_pkg::IN_TDATA_W-1:0]      in_tdata,   // [17:0] sample_pa
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dmmt_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [3:0] day_slot,
                                                           // [24:4] day_min,
                                                           // [42:25] day_max,
                                                           // [68:43] day_mean_q8
  output logic                                 out_tuser,  // [0] accepted
  output logic                                 out_tlast   // day_end
);

  dmmt_pkg::state_t state_r, state_nxt;

  // Day statistics
  logic [dmmt_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [dmmt_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [dmmt_pkg::MIN_W-1:0]    min_r, min_nxt;
  logic [dmmt_pkg::MAX_W-1:0]    max_r, max_nxt;
  logic [dmmt_pkg::SLOT_W-1:0]   slot_r, slot_nxt;

  // Per-beat working registers
  logic [dmmt_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                          ends_r, ends_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [dmmt_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                          out_user_r, out_user_nxt;
  logic                          out_last_r, out_last_nxt;

  // Sequencer outputs
  logic                          in_accept;
  logic                          div_start;
  logic                          out_free;
  logic                          out_load;

  // Divider
  logic [dmmt_pkg::MEAN_W-1:0]   quotient;
  dmmt_pkg::div_sts_t            div_sts;

  logic [dmmt_pkg::COUNT_W-1:0]  count_inc;
  logic [dmmt_pkg::SLOT_W:0]     slot_inc;
  logic                          sample_ok;
  logic [dmmt_pkg::MEAN_W-1:0]   mean;

  dmmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, {dmmt_pkg::FRAC_W{1'b0}}}),
    .divisor  (count_r),
    .quotient (quotient),
    .sts      (div_sts)
  );

  // ---------------------------------------------------------------------
  // Sequencer: capture -> update stats -> divide -> hand result to output reg
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmmt_pkg::ST_IDLE:      if (in_tvalid) state_nxt = dmmt_pkg::ST_UPDATE;
      dmmt_pkg::ST_UPDATE:    state_nxt = dmmt_pkg::ST_DIV_START;
      dmmt_pkg::ST_DIV_START: state_nxt = dmmt_pkg::ST_DIV_WAIT;
      dmmt_pkg::ST_DIV_WAIT:  if (div_sts.done) state_nxt = dmmt_pkg::ST_DONE;
      dmmt_pkg::ST_DONE:      if (out_free) state_nxt = dmmt_pkg::ST_IDLE;
      default:                state_nxt = dmmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    in_tready = (state_r == dmmt_pkg::ST_IDLE);
    in_accept = in_tvalid && in_tready;
    div_start = (state_r == dmmt_pkg::ST_DIV_START);
    out_load  = (state_r == dmmt_pkg::ST_DONE) && out_free;
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  always_comb begin
    count_inc = count_r + 1'b1;
    slot_inc  = {1'b0, slot_r} + 1'b1;
    sample_ok = (sample_r != '0);
    // Empty day reports a zero mean (divider would give all ones)
    mean      = (count_r == '0) ? '0 : quotient;
  end

  always_comb begin
    sample_nxt    = sample_r;
    ends_nxt      = ends_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    if (in_accept) begin
      sample_nxt = in_tdata[dmmt_pkg::SAMPLE_W-1:0];
    end

    // Zero sample: stats untouched, no day end
    if (state_r == dmmt_pkg::ST_UPDATE) begin
      ends_nxt = 1'b0;
      if (sample_ok) begin
        sum_nxt   = sum_r + dmmt_pkg::SUM_W'(sample_r);
        count_nxt = count_inc;
        if (dmmt_pkg::MIN_W'(sample_r) < min_r) min_nxt = dmmt_pkg::MIN_W'(sample_r);
        if (sample_r > max_r) max_nxt = sample_r;
        ends_nxt  = (count_inc >= dmmt_pkg::SAMPLES_PER_DAY);
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = dmmt_pkg::OUT_TDATA_W'({mean, max_r, min_r, slot_r});
      out_user_nxt  = sample_ok;
      out_last_nxt  = ends_r;
      // Day rollover after the finished day has been reported
      if (ends_r) begin
        slot_nxt  = (slot_inc >= (dmmt_pkg::SLOT_W + 1)'(dmmt_pkg::DAYS))
                    ? '0 : slot_inc[dmmt_pkg::SLOT_W-1:0];
        sum_nxt   = '0;
        count_nxt = '0;
        min_nxt   = dmmt_pkg::MIN_EMPTY;
        max_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmmt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      min_r       <= dmmt_pkg::MIN_EMPTY;
      max_r       <= '0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      slot_r      <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    ends_r     <= ends_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dmmt_pkg::SAMPLES_PER_DAY)
    else $error("day count above samples per day");

  a_empty_day: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0) && (max_r == '0) && (min_r == dmmt_pkg::MIN_EMPTY))
    else $error("empty day with stale statistics");

  a_rollover: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ends_r) |=> (count_r == '0) && out_tvalid && out_tlast)
    else $error("day end did not restart the day");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == dmmt_pkg::ST_DIV_WAIT))
    else $error("divider finished outside wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready && (sample_r == $past(in_tdata[dmmt_pkg::SAMPLE_W-1:0])))
    else $error("sample not captured on accept");

endmodule
